[hw/rtl/btc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths, register indexes and limits for the barometric compensation block.
package btc_pkg;

   // Field widths.
   localparam int CalWidth  = 16;
   localparam int RawWidth  = 24;
   localparam int TempWidth = 15;
   localparam int PresWidth = 17;
   localparam int CsrIndexWidth = 3;

   // Width of the corrected offset and sensitivity terms.
   localparam int WideWidth = 42;

   // Register indexes on the configuration port.
   localparam logic [CsrIndexWidth-1:0] CsrPressureSensitivity  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrPressureOffset       = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrSensitivityTempCoeff = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrOffsetTempCoeff      = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrReferenceTemperature = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CsrTemperatureCoeff     = 3'd5;

   // Output limits.
   localparam logic signed [TempWidth-1:0] TempMin = -15'sd4000;
   localparam logic signed [TempWidth-1:0] TempMax = 15'sd8500;
   localparam logic [PresWidth-1:0] PresMin = 17'd1000;
   localparam logic [PresWidth-1:0] PresMax = 17'd120000;

   // Pipeline latency from accepted request to result strobe.
   localparam int Latency = 11;

   // Factory calibration words.
   typedef struct packed {
      logic [CalWidth-1:0] pressure_sensitivity;
      logic [CalWidth-1:0] pressure_offset;
      logic [CalWidth-1:0] sensitivity_temp_coeff;
      logic [CalWidth-1:0] offset_temp_coeff;
      logic [CalWidth-1:0] reference_temperature;
      logic [CalWidth-1:0] temperature_coeff;
   } cal_type;

   // Hand-off from the temperature front end to the pressure back end.
   typedef struct packed {
      logic                          valid;
      logic [RawWidth-1:0]           raw_pressure;
      logic signed [WideWidth-1:0]   off;
      logic signed [WideWidth-1:0]   sens;
      logic signed [TempWidth-1:0]   temperature;
   } sample_type;

endpackage

[hw/rtl/btc_cal_regs.sv]
`timescale 1ns / 1ps
// Calibration register file written through the configuration port.
module btc_cal_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [btc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [btc_pkg::CalWidth-1:0]        csr_write_data,
   output btc_pkg::cal_type                    cal
);

   btc_pkg::cal_type cal_ff;
   btc_pkg::cal_type cal_in;

   // Decode the register index; unknown indexes leave everything unchanged.
   always_comb begin
      cal_in = cal_ff;
      if (csr_write_enable) begin
         case (csr_index)
            btc_pkg::CsrPressureSensitivity:  cal_in.pressure_sensitivity   = csr_write_data;
            btc_pkg::CsrPressureOffset:       cal_in.pressure_offset        = csr_write_data;
            btc_pkg::CsrSensitivityTempCoeff: cal_in.sensitivity_temp_coeff = csr_write_data;
            btc_pkg::CsrOffsetTempCoeff:      cal_in.offset_temp_coeff      = csr_write_data;
            btc_pkg::CsrReferenceTemperature: cal_in.reference_temperature  = csr_write_data;
            btc_pkg::CsrTemperatureCoeff:     cal_in.temperature_coeff      = csr_write_data;
            default: cal_in = cal_ff;
         endcase
      end
   end

   // Calibration words reset to zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   assign cal = cal_ff;

endmodule

[hw/rtl/btc_front.sv]
`timescale 1ns / 1ps
// Six-stage front end: temperature, offset and sensitivity with second-order terms.
module btc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [btc_pkg::RawWidth-1:0]   raw_pressure,
   input  logic [btc_pkg::RawWidth-1:0]   raw_temperature,
   input  btc_pkg::cal_type               cal,
   output btc_pkg::sample_type            sample
);

   // Stage 1: temperature difference.
   logic                         s1_valid_ff;
   logic [btc_pkg::RawWidth-1:0] s1_d1_ff;
   logic signed [24:0]           s1_dt_ff;
   logic signed [24:0]           s1_dt_in;

   // Stage 2: the four products of the difference.
   logic                         s2_valid_ff;
   logic [btc_pkg::RawWidth-1:0] s2_d1_ff;
   logic signed [41:0]           s2_tprod_ff, s2_tprod_in;
   logic signed [41:0]           s2_oprod_ff, s2_oprod_in;
   logic signed [41:0]           s2_sprod_ff, s2_sprod_in;
   logic signed [49:0]           s2_dd_ff, s2_dd_in;

   // Stage 3: first-order terms.
   logic                         s3_valid_ff;
   logic [btc_pkg::RawWidth-1:0] s3_d1_ff;
   logic signed [18:0]           s3_q_ff, s3_q_in;
   logic signed [18:0]           s3_temp1_ff, s3_temp1_in;
   logic signed [35:0]           s3_off1_ff, s3_off1_in;
   logic signed [35:0]           s3_sens1_ff, s3_sens1_in;
   logic [17:0]                  s3_t2_ff;
   logic                         s3_low_ff, s3_low_in;
   logic                         s3_vlow_ff, s3_vlow_in;
   logic signed [41:0]           tprod_bias;
   logic signed [41:0]           oprod_bias;
   logic signed [41:0]           sprod_bias;
   logic signed [34:0]           off_div;
   logic signed [33:0]           sens_div;

   // Stage 4: squares for the second-order terms.
   logic                         s4_valid_ff;
   logic [btc_pkg::RawWidth-1:0] s4_d1_ff;
   logic signed [18:0]           s4_temp1_ff;
   logic signed [35:0]           s4_off1_ff;
   logic signed [35:0]           s4_sens1_ff;
   logic [17:0]                  s4_t2_ff;
   logic                         s4_low_ff;
   logic                         s4_vlow_ff;
   logic [35:0]                  s4_sq1_ff, s4_sq1_in;
   logic [35:0]                  s4_sq2_ff, s4_sq2_in;
   logic signed [37:0]           sq1_full;
   logic signed [19:0]           q_shift;
   logic signed [39:0]           sq2_full;

   // Stage 5: second-order corrections and final temperature.
   logic                         s5_valid_ff;
   logic [btc_pkg::RawWidth-1:0] s5_d1_ff;
   logic signed [35:0]           s5_off1_ff;
   logic signed [35:0]           s5_sens1_ff;
   logic [39:0]                  s5_off2_ff, s5_off2_in;
   logic [39:0]                  s5_sens2_ff, s5_sens2_in;
   logic signed [btc_pkg::TempWidth-1:0] s5_temp_ff, s5_temp_in;
   logic [39:0]                  five_sq;
   logic [39:0]                  seven_sq;
   logic [39:0]                  eleven_sq;
   logic signed [19:0]           temp_full;

   // Stage 6: corrected offset and sensitivity.
   logic                         s6_valid_ff;
   logic [btc_pkg::RawWidth-1:0] s6_d1_ff;
   logic signed [btc_pkg::WideWidth-1:0] s6_off_ff, s6_off_in;
   logic signed [btc_pkg::WideWidth-1:0] s6_sens_ff, s6_sens_in;
   logic signed [btc_pkg::TempWidth-1:0] s6_temp_ff;

   // The reference temperature is stored divided by 256.
   assign s1_dt_in = $signed({1'b0, raw_temperature})
                   - $signed({1'b0, cal.reference_temperature, 8'd0});

   // Products of the difference with its coefficients and with itself.
   assign s2_tprod_in = s1_dt_ff * $signed({1'b0, cal.temperature_coeff});
   assign s2_oprod_in = s1_dt_ff * $signed({1'b0, cal.offset_temp_coeff});
   assign s2_sprod_in = s1_dt_ff * $signed({1'b0, cal.sensitivity_temp_coeff});
   assign s2_dd_in    = s1_dt_ff * s1_dt_ff;

   // Divisions truncate toward zero: negative values get a bias before the shift.
   always_comb begin
      tprod_bias  = s2_tprod_ff + (s2_tprod_ff[41] ? 42'sd8388607 : 42'sd0);
      oprod_bias  = s2_oprod_ff + (s2_oprod_ff[41] ? 42'sd127 : 42'sd0);
      sprod_bias  = s2_sprod_ff + (s2_sprod_ff[41] ? 42'sd255 : 42'sd0);
      s3_q_in     = tprod_bias[41:23];
      off_div     = oprod_bias[41:7];
      sens_div    = sprod_bias[41:8];
      s3_temp1_in = 19'sd2000 + s3_q_in;
      s3_off1_in  = $signed({4'd0, cal.pressure_offset, 16'd0}) + off_div;
      s3_sens1_in = $signed({5'd0, cal.pressure_sensitivity, 15'd0}) + sens_div;
      // Below 20 C the first-order temperature offset is negative.
      s3_low_in   = s3_q_in[18];
      // Below -15 C.
      s3_vlow_in  = s3_q_in < -19'sd3500;
   end

   // Squares of the distances from the two thresholds.
   always_comb begin
      sq1_full  = s3_q_ff * s3_q_ff;
      q_shift   = s3_q_ff + 20'sd3500;
      sq2_full  = q_shift * q_shift;
      s4_sq1_in = sq1_full[35:0];
      s4_sq2_in = sq2_full[35:0];
   end

   // Constant multiples by shift and add; all terms are non-negative.
   always_comb begin
      five_sq   = {2'd0, s4_sq1_ff, 2'd0} + {4'd0, s4_sq1_ff};
      seven_sq  = {1'b0, s4_sq2_ff, 3'd0} - {4'd0, s4_sq2_ff};
      eleven_sq = {1'b0, s4_sq2_ff, 3'd0} + {3'd0, s4_sq2_ff, 1'b0} + {4'd0, s4_sq2_ff};
      s5_off2_in  = '0;
      s5_sens2_in = '0;
      temp_full   = 20'(s4_temp1_ff);
      if (s4_low_ff) begin
         s5_off2_in  = (five_sq >> 1) + (s4_vlow_ff ? seven_sq : 40'd0);
         s5_sens2_in = (five_sq >> 2) + (s4_vlow_ff ? (eleven_sq >> 1) : 40'd0);
         temp_full   = 20'(s4_temp1_ff) - $signed({2'd0, s4_t2_ff});
      end
      // Saturate the temperature.
      if (temp_full < btc_pkg::TempMin) begin
         s5_temp_in = btc_pkg::TempMin;
      end else if (temp_full > btc_pkg::TempMax) begin
         s5_temp_in = btc_pkg::TempMax;
      end else begin
         s5_temp_in = temp_full[btc_pkg::TempWidth-1:0];
      end
   end

   // Apply the corrections.
   assign s6_off_in  = btc_pkg::WideWidth'(s5_off1_ff) - $signed({2'd0, s5_off2_ff});
   assign s6_sens_in = btc_pkg::WideWidth'(s5_sens1_ff) - $signed({2'd0, s5_sens2_ff});

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_d1_ff    <= raw_pressure;
      s1_dt_ff    <= s1_dt_in;

      s2_d1_ff    <= s1_d1_ff;
      s2_tprod_ff <= s2_tprod_in;
      s2_oprod_ff <= s2_oprod_in;
      s2_sprod_ff <= s2_sprod_in;
      s2_dd_ff    <= s2_dd_in;

      s3_d1_ff    <= s2_d1_ff;
      s3_q_ff     <= s3_q_in;
      s3_temp1_ff <= s3_temp1_in;
      s3_off1_ff  <= s3_off1_in;
      s3_sens1_ff <= s3_sens1_in;
      s3_t2_ff    <= s2_dd_ff[48:31];
      s3_low_ff   <= s3_low_in;
      s3_vlow_ff  <= s3_vlow_in;

      s4_d1_ff    <= s3_d1_ff;
      s4_temp1_ff <= s3_temp1_ff;
      s4_off1_ff  <= s3_off1_ff;
      s4_sens1_ff <= s3_sens1_ff;
      s4_t2_ff    <= s3_t2_ff;
      s4_low_ff   <= s3_low_ff;
      s4_vlow_ff  <= s3_vlow_ff;
      s4_sq1_ff   <= s4_sq1_in;
      s4_sq2_ff   <= s4_sq2_in;

      s5_d1_ff    <= s4_d1_ff;
      s5_off1_ff  <= s4_off1_ff;
      s5_sens1_ff <= s4_sens1_ff;
      s5_off2_ff  <= s5_off2_in;
      s5_sens2_ff <= s5_sens2_in;
      s5_temp_ff  <= s5_temp_in;

      s6_d1_ff    <= s5_d1_ff;
      s6_off_ff   <= s6_off_in;
      s6_sens_ff  <= s6_sens_in;
      s6_temp_ff  <= s5_temp_ff;
   end

   always_comb begin
      sample.valid        = s6_valid_ff;
      sample.raw_pressure = s6_d1_ff;
      sample.off          = s6_off_ff;
      sample.sens         = s6_sens_ff;
      sample.temperature  = s6_temp_ff;
   end

   // The very-cold correction only ever applies on top of the cold one.
   a_vlow_implies_low: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && s3_vlow_ff |-> s3_low_ff)
      else $error("very-cold flag set without the cold flag");

   // Above 20 C no second-order terms reach the corrections stage.
   a_warm_no_corr: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && !s4_low_ff |=> s5_off2_ff == 40'd0 && s5_sens2_ff == 40'd0)
      else $error("second-order correction applied above 20 C");

   // Valid bits advance one stage per cycle.
   a_valid_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> ##5 s6_valid_ff)
      else $error("front end lost a request");

endmodule

[hw/rtl/btc_pressure.sv]
`timescale 1ns / 1ps
// Five-stage back end: split pressure product, scaling and saturation.
module btc_pressure (
   input  logic                                 clock,
   input  logic                                 reset,
   input  btc_pkg::sample_type                  sample,
   output logic                                 rsp_strobe,
   output logic signed [btc_pkg::TempWidth-1:0] rsp_temperature,
   output logic [btc_pkg::PresWidth-1:0]        rsp_pressure
);

   // Stage 7: partial products of the raw pressure and the sensitivity.
   logic                                 s7_valid_ff;
   logic [44:0]                          s7_lo_ff, s7_lo_in;
   logic signed [45:0]                   s7_hi_ff, s7_hi_in;
   logic signed [btc_pkg::WideWidth-1:0] s7_off_ff;
   logic signed [btc_pkg::TempWidth-1:0] s7_temp_ff;

   // Stage 8: full product.
   logic                                 s8_valid_ff;
   logic signed [66:0]                   s8_prod_ff, s8_prod_in;
   logic signed [btc_pkg::WideWidth-1:0] s8_off_ff;
   logic signed [btc_pkg::TempWidth-1:0] s8_temp_ff;

   // Stage 9: product divided by 2^21.
   logic                                 s9_valid_ff;
   logic signed [45:0]                   s9_scaled_ff, s9_scaled_in;
   logic signed [btc_pkg::WideWidth-1:0] s9_off_ff;
   logic signed [btc_pkg::TempWidth-1:0] s9_temp_ff;
   logic signed [66:0]                   prod_bias;

   // Stage 10: offset removed.
   logic                                 s10_valid_ff;
   logic signed [46:0]                   s10_diff_ff, s10_diff_in;
   logic signed [btc_pkg::TempWidth-1:0] s10_temp_ff;

   // Output register.
   logic                                 out_valid_ff;
   logic [btc_pkg::PresWidth-1:0]        out_pres_ff, out_pres_in;
   logic signed [btc_pkg::TempWidth-1:0] out_temp_ff;
   logic signed [46:0]                   diff_bias;
   logic signed [31:0]                   pres_full;

   // The sensitivity is split into an unsigned low half and a signed high half.
   assign s7_lo_in = sample.raw_pressure * sample.sens[20:0];
   assign s7_hi_in = $signed({1'b0, sample.raw_pressure}) * $signed(sample.sens[41:21]);

   // Recombine the halves.
   assign s8_prod_in = (67'(s7_hi_ff) <<< 21) + $signed({22'd0, s7_lo_ff});

   // Truncating divisions by powers of two.
   always_comb begin
      prod_bias    = s8_prod_ff + (s8_prod_ff[66] ? 67'sd2097151 : 67'sd0);
      s9_scaled_in = prod_bias[66:21];
   end

   assign s10_diff_in = 47'(s9_scaled_ff) - 47'(s9_off_ff);

   // Final scaling and saturation of the pressure.
   always_comb begin
      diff_bias = s10_diff_ff + (s10_diff_ff[46] ? 47'sd32767 : 47'sd0);
      pres_full = diff_bias[46:15];
      if (pres_full < $signed({15'd0, btc_pkg::PresMin})) begin
         out_pres_in = btc_pkg::PresMin;
      end else if (pres_full > $signed({15'd0, btc_pkg::PresMax})) begin
         out_pres_in = btc_pkg::PresMax;
      end else begin
         out_pres_in = pres_full[btc_pkg::PresWidth-1:0];
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff  <= sample.valid;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= s8_valid_ff;
         s10_valid_ff <= s9_valid_ff;
         out_valid_ff <= s10_valid_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s7_lo_ff     <= s7_lo_in;
      s7_hi_ff     <= s7_hi_in;
      s7_off_ff    <= sample.off;
      s7_temp_ff   <= sample.temperature;

      s8_prod_ff   <= s8_prod_in;
      s8_off_ff    <= s7_off_ff;
      s8_temp_ff   <= s7_temp_ff;

      s9_scaled_ff <= s9_scaled_in;
      s9_off_ff    <= s8_off_ff;
      s9_temp_ff   <= s8_temp_ff;

      s10_diff_ff  <= s10_diff_in;
      s10_temp_ff  <= s9_temp_ff;

      out_pres_ff  <= out_pres_in;
      out_temp_ff  <= s10_temp_ff;
   end

   assign rsp_strobe      = out_valid_ff;
   assign rsp_temperature = out_temp_ff;
   assign rsp_pressure    = out_pres_ff;

   // A strobed pressure is always within its saturation limits.
   a_pres_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_pres_ff >= btc_pkg::PresMin && out_pres_ff <= btc_pkg::PresMax)
      else $error("pressure outside its limits");

   // Every sample leaving the front end turns into one strobe.
   a_back_latency: assert property (@(posedge clock) disable iff (reset)
      sample.valid |-> ##5 out_valid_ff)
      else $error("back end lost a request");

   // The recombined product agrees in sign with its high partial product.
   a_prod_sign: assert property (@(posedge clock) disable iff (reset)
      s7_valid_ff && s7_hi_ff[45] |=> s8_prod_ff[66])
      else $error("product sign lost in recombination");

endmodule

[hw/rtl/baro_temperature_compensation.sv]
`timescale 1ns / 1ps
// Top level of the barometric temperature and pressure compensation pipeline.
//
//   Channel   Ports                                    Handshake
//   request   req_raw_pressure, req_raw_temperature    start high and busy low
//   result    rsp_temperature, rsp_pressure            rsp_strobe, one cycle
//   config    csr_index, csr_write_data                csr_write_enable
//
// A new request can be accepted in every clock cycle; the result comes out after passing
// through the eleven register stages of the datapath
// (the split 24 by 42 bit pressure product takes two of them).
// Reset is synchronous; busy is high from reset until the cycle after reset drops.
// The receiver cannot stall, so the pipeline advances on every clock.
module baro_temperature_compensation (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [btc_pkg::RawWidth-1:0]         req_raw_pressure,
   input  logic [btc_pkg::RawWidth-1:0]         req_raw_temperature,
   output logic                                 rsp_strobe,
   output logic signed [btc_pkg::TempWidth-1:0] rsp_temperature,
   output logic [btc_pkg::PresWidth-1:0]        rsp_pressure,
   input  logic                                 csr_write_enable,
   input  logic [btc_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [btc_pkg::CalWidth-1:0]         csr_write_data
);

   logic                busy_ff;
   logic                accept;
   btc_pkg::cal_type    cal;
   btc_pkg::sample_type sample;

   // Hold off requests while in reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // Calibration registers.
   btc_cal_regs u_cal_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cal              (cal)
   );

   // Temperature, offset and sensitivity.
   btc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (accept),
      .raw_pressure    (req_raw_pressure),
      .raw_temperature (req_raw_temperature),
      .cal             (cal),
      .sample          (sample)
   );

   // Pressure scaling and output register.
   btc_pressure u_pressure (
      .clock           (clock),
      .reset           (reset),
      .sample          (sample),
      .rsp_strobe      (rsp_strobe),
      .rsp_temperature (rsp_temperature),
      .rsp_pressure    (rsp_pressure)
   );

   // Every accepted request produces a result after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##11 rsp_strobe)
      else $error("result missing after an accepted request");

   // No result appears without a request accepted the latency earlier.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 11))
      else $error("result without a matching request");

   // A strobed temperature is always within its saturation limits.
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_temperature >= btc_pkg::TempMin
                  && rsp_temperature <= btc_pkg::TempMax)
      else $error("temperature outside its limits");

endmodule

[test/baro_temperature_compensation_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the barometric temperature and pressure compensation block.
module baro_temperature_compensation_test;

   localparam int ClockPeriod = 10;
   localparam int QuietLimit  = 1000;

   // Indexes past the last calibration word; writes there must leave the block unchanged.
   localparam logic [btc_pkg::CsrIndexWidth-1:0] CsrUnmappedLow  = 3'd6;
   localparam logic [btc_pkg::CsrIndexWidth-1:0] CsrUnmappedHigh = 3'd7;

   // Typical factory calibration of a production part.
   localparam btc_pkg::cal_type Datasheet = '{
      pressure_sensitivity:   16'd40127,
      pressure_offset:        16'd36924,
      sensitivity_temp_coeff: 16'd23317,
      offset_temp_coeff:      16'd23282,
      reference_temperature:  16'd33464,
      temperature_coeff:      16'd28312
   };

   typedef struct {
      logic signed [btc_pkg::TempWidth-1:0] temperature;
      logic [btc_pkg::PresWidth-1:0]        pressure;
   } reading_type;

   // Mirrors the calibration words and predicts the compensated reading of each request.
   class compensation_checker;
      btc_pkg::cal_type cal = '0;
      reading_type      expected_readings[$];
      int               mismatches = 0;
      int               checked = 0;
      int               cold = 0;
      int               frigid = 0;
      int               saturated = 0;

      function void write_cal(logic [btc_pkg::CsrIndexWidth-1:0] index,
                              logic [btc_pkg::CalWidth-1:0] value);
         case (index)
            btc_pkg::CsrPressureSensitivity:  cal.pressure_sensitivity = value;
            btc_pkg::CsrPressureOffset:       cal.pressure_offset = value;
            btc_pkg::CsrSensitivityTempCoeff: cal.sensitivity_temp_coeff = value;
            btc_pkg::CsrOffsetTempCoeff:      cal.offset_temp_coeff = value;
            btc_pkg::CsrReferenceTemperature: cal.reference_temperature = value;
            btc_pkg::CsrTemperatureCoeff:     cal.temperature_coeff = value;
            default: ;
         endcase
      endfunction

      function reading_type compensate(logic [btc_pkg::RawWidth-1:0] raw_p,
                                       logic [btc_pkg::RawWidth-1:0] raw_t);
         longint      d1, dt, temp, off, sens, t2, off2, sens2, sq, p;
         reading_type r;
         d1 = longint'(raw_p);
         dt = longint'(raw_t) - longint'(cal.reference_temperature) * 256;
         temp = 2000 + dt * longint'(cal.temperature_coeff) / 64'sd8388608;
         off = longint'(cal.pressure_offset) * 65536
               + longint'(cal.offset_temp_coeff) * dt / 128;
         sens = longint'(cal.pressure_sensitivity) * 32768
                + longint'(cal.sensitivity_temp_coeff) * dt / 256;
         t2 = 0;
         off2 = 0;
         sens2 = 0;
         // Second-order terms; both thresholds look at the first-order temperature.
         if (temp < 2000) begin
            cold++;
            t2 = dt * dt / 64'sd2147483648;
            sq = (temp - 2000) * (temp - 2000);
            off2 = 5 * sq / 2;
            sens2 = 5 * sq / 4;
            if (temp < -1500) begin
               frigid++;
               sq = (temp + 1500) * (temp + 1500);
               off2 += 7 * sq;
               sens2 += 11 * sq / 2;
            end
         end
         temp -= t2;
         off -= off2;
         sens -= sens2;
         p = (d1 * sens / 64'sd2097152 - off) / 32768;
         // Saturate both outputs to their stated ranges.
         if (temp < longint'(btc_pkg::TempMin) || temp > longint'(btc_pkg::TempMax) ||
             p < longint'(btc_pkg::PresMin) || p > longint'(btc_pkg::PresMax)) begin
            saturated++;
         end
         if (temp < longint'(btc_pkg::TempMin)) begin
            temp = longint'(btc_pkg::TempMin);
         end else if (temp > longint'(btc_pkg::TempMax)) begin
            temp = longint'(btc_pkg::TempMax);
         end
         if (p < longint'(btc_pkg::PresMin)) begin
            p = longint'(btc_pkg::PresMin);
         end else if (p > longint'(btc_pkg::PresMax)) begin
            p = longint'(btc_pkg::PresMax);
         end
         r.temperature = temp[btc_pkg::TempWidth-1:0];
         r.pressure = p[btc_pkg::PresWidth-1:0];
         return r;
      endfunction

      function void note_request(logic [btc_pkg::RawWidth-1:0] raw_p,
                                 logic [btc_pkg::RawWidth-1:0] raw_t);
         expected_readings.push_back(compensate(raw_p, raw_t));
      endfunction

      function void check_reading(logic signed [btc_pkg::TempWidth-1:0] t,
                                  logic [btc_pkg::PresWidth-1:0] p);
         reading_type want;
         if (expected_readings.size() == 0) begin
            mismatches++;
            $error("reading with no request waiting: temperature %0d, pressure %0d", t, p);
            return;
         end
         want = expected_readings.pop_front();
         checked++;
         if (t !== want.temperature) begin
            mismatches++;
            $error("temperature: expected %0d, actual %0d", want.temperature, t);
         end
         if (p !== want.pressure) begin
            mismatches++;
            $error("pressure: expected %0d, actual %0d", want.pressure, p);
         end
      endfunction

      function int outstanding();
         return expected_readings.size();
      endfunction
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic [btc_pkg::RawWidth-1:0]         req_raw_pressure;
   logic [btc_pkg::RawWidth-1:0]         req_raw_temperature;
   logic                                 rsp_strobe;
   logic signed [btc_pkg::TempWidth-1:0] rsp_temperature;
   logic [btc_pkg::PresWidth-1:0]        rsp_pressure;
   logic                                 csr_write_enable;
   logic [btc_pkg::CsrIndexWidth-1:0]    csr_index;
   logic [btc_pkg::CalWidth-1:0]         csr_write_data;

   compensation_checker board = new();
   int sender_idle_pct = 31;
   int quiet_cycles = 0;
   int requests_sent = 0;

   baro_temperature_compensation dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_raw_pressure    (req_raw_pressure),
      .req_raw_temperature (req_raw_temperature),
      .rsp_strobe          (rsp_strobe),
      .rsp_temperature     (rsp_temperature),
      .rsp_pressure        (rsp_pressure),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // Check readings, record accepted requests and watch for a stalled run.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            board.check_reading(rsp_temperature, rsp_pressure);
         end
         if (start && !busy) begin
            board.note_request(req_raw_pressure, req_raw_temperature);
            requests_sent++;
         end
      end
      if ((start && !busy) || rsp_strobe || csr_write_enable) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("Timeout: no request, reading or register write for %0d cycles.", QuietLimit);
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [btc_pkg::RawWidth-1:0] clamp_raw(longint value);
      if (value < 0) begin
         return '0;
      end
      if (value > longint'({btc_pkg::RawWidth{1'b1}})) begin
         return '1;
      end
      return btc_pkg::RawWidth'(value);
   endfunction

   // Offer one request after a random gap and hold it until it is taken.
   task automatic send_request(input logic [btc_pkg::RawWidth-1:0] raw_p,
                               input logic [btc_pkg::RawWidth-1:0] raw_t);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_raw_pressure <= raw_p;
      req_raw_temperature <= raw_t;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Random request, mostly near the reference temperature so that the cold paths are reached.
   task automatic send_random_request();
      longint                       center;
      longint                       d2;
      logic [btc_pkg::RawWidth-1:0] d1;
      int unsigned                  mode;
      center = longint'(board.cal.reference_temperature) * 256;
      mode = $urandom_range(9);
      if ($urandom_range(1) == 0) begin
         d1 = btc_pkg::RawWidth'($urandom);
      end else begin
         d1 = btc_pkg::RawWidth'(9085466 - (1 << 21) + $urandom_range(1 << 22));
      end
      if (mode < 2) begin
         d2 = longint'($urandom & 32'hFFFFFF);
      end else if (mode < 5) begin
         d2 = center + longint'($urandom_range(1 << 22)) - (1 << 21);
      end else if (mode < 8) begin
         d2 = center - longint'($urandom_range(1 << 21));
      end else begin
         d2 = center + longint'($urandom_range(8192)) - 4096;
      end
      send_request(d1, clamp_raw(d2));
   endtask

   // Stop sending and let every outstanding reading come out.
   task automatic wait_for_readings();
      start <= 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (btc_pkg::Latency) @(negedge clock);
   endtask

   task automatic write_csr(input logic [btc_pkg::CsrIndexWidth-1:0] index,
                            input logic [btc_pkg::CalWidth-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      board.write_cal(index, value);
      @(negedge clock);
   endtask

   // Load all six calibration words, with stray writes to unmapped indexes around them.
   task automatic load_cal(input btc_pkg::cal_type words);
      write_csr(CsrUnmappedLow, btc_pkg::CalWidth'($urandom));
      write_csr(btc_pkg::CsrPressureSensitivity, words.pressure_sensitivity);
      write_csr(btc_pkg::CsrPressureOffset, words.pressure_offset);
      write_csr(btc_pkg::CsrSensitivityTempCoeff, words.sensitivity_temp_coeff);
      write_csr(btc_pkg::CsrOffsetTempCoeff, words.offset_temp_coeff);
      write_csr(btc_pkg::CsrReferenceTemperature, words.reference_temperature);
      write_csr(btc_pkg::CsrTemperatureCoeff, words.temperature_coeff);
      write_csr(CsrUnmappedHigh, btc_pkg::CalWidth'($urandom));
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic btc_pkg::cal_type near_datasheet();
      btc_pkg::cal_type c;
      c = Datasheet;
      for (int i = 0; i < 6; i++) begin
         c[16*i +: 16] = c[16*i +: 16] + btc_pkg::CalWidth'($urandom_range(8191)) - 16'd4096;
      end
      return c;
   endfunction

   initial begin : stimulus
      int               boundary_temps[4] = '{2000, -1500, -4000, 8500};
      int               nudges[5] = '{-320, -1, 0, 1, 320};
      longint           dt0;
      btc_pkg::cal_type c;

      reset = 1'b1;
      start = 1'b0;
      req_raw_pressure = '0;
      req_raw_temperature = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Uncalibrated block straight out of reset.
      send_request('0, '0);
      send_request('1, '1);
      wait_for_readings();

      // Raw extremes, both temperature thresholds and the temperature limits under typical calibration.
      load_cal(Datasheet);
      send_request('0, '0);
      send_request('0, '1);
      send_request('1, '0);
      send_request('1, '1);
      foreach (boundary_temps[i]) begin
         dt0 = (longint'(boundary_temps[i]) - 2000) * 8388608
               / longint'(Datasheet.temperature_coeff);
         foreach (nudges[k]) begin
            send_request(btc_pkg::RawWidth'(9085466), clamp_raw(
               longint'(Datasheet.reference_temperature) * 256 + dt0 + nudges[k]));
         end
      end
      wait_for_readings();

      // Random requests over several calibration sets and sender idle rates.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: c = '1;
            4: c = '0;
            2, 6: c = {$urandom, $urandom, $urandom};
            default: c = near_datasheet();
         endcase
         sender_idle_pct = (ph < 3) ? 31 : (ph < 6) ? 50 : 0;
         load_cal(c);
         repeat (100) begin
            send_random_request();
            if ($urandom_range(149) == 0) begin
               wait_for_readings();
            end
         end
         wait_for_readings();
      end

      $display("Sent %0d requests over ten calibration sets, %0d readings checked.",
               requests_sent, board.checked);
      $display("First-order temperature below 20 C: %0d, below -15 C: %0d, saturated: %0d.",
               board.cold, board.frigid, board.saturated);
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/btc_pkg.sv
hw/rtl/btc_cal_regs.sv
hw/rtl/btc_front.sv
hw/rtl/btc_pressure.sv
hw/rtl/baro_temperature_compensation.sv
test/baro_temperature_compensation_test.sv
